@@ src/lpcd_pkg.sv @@
// Package for the length-prefixed channel demultiplexer: sizes, command and
// status codes, and the descriptor passed from the front end to the back end.
// Depends on nothing.
`default_nettype none
package lpcd_pkg;

  localparam int NUM_CHANNELS  = 8;
  localparam int CHANNEL_DEPTH = 256;
  localparam int MAX_BURST     = 64;

  localparam int CH_W    = $clog2(NUM_CHANNELS);
  localparam int POS_W   = $clog2(CHANNEL_DEPTH);
  localparam int CNT_W   = POS_W + 1;
  localparam int ADDR_W  = CH_W + POS_W;
  localparam int STORE_DEPTH = NUM_CHANNELS * CHANNEL_DEPTH;
  localparam int BURST_W = $clog2(MAX_BURST + 1);

  // Commands.
  localparam logic [2:0] CMD_LINK   = 3'd0;
  localparam logic [2:0] CMD_POP    = 3'd1;
  localparam logic [2:0] CMD_PEEK   = 3'd2;
  localparam logic [2:0] CMD_SELECT = 3'd3;
  localparam logic [2:0] CMD_UNMARK = 3'd4;
  localparam logic [2:0] CMD_CLEAR  = 3'd5;

  // Result status codes.
  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_COMMIT  = 3'd1;
  localparam logic [2:0] ST_IGNORED = 3'd2;
  localparam logic [2:0] ST_EMPTY   = 3'd3;
  localparam logic [2:0] ST_OVERRUN = 3'd4;
  localparam logic [2:0] ST_NONE    = 3'd5;
  localparam logic [2:0] ST_BADLEN  = 3'd6;

  // Parser states: below HDR_CHAN the length bytes are being collected.
  localparam logic [2:0] HDR_CHAN = 3'd4;
  localparam logic [2:0] HDR_BODY = 3'd5;

  typedef struct packed {
    logic [2:0]         status;
    logic [7:0]         chan;
    logic [8:0]         fill;
    logic [8:0]         fresh;
    logic               burst;
    logic [POS_W-1:0]   head;
    logic [BURST_W-1:0] cnt;
  } desc_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        data;
  } wr_t;

  typedef struct packed {
    logic full;
    logic empty;
    logic burst_pending;
  } q_stat_t;

endpackage
`default_nettype wire

@@ src/lpcd_in_if.sv @@
// Input channel interface of the demultiplexer: valid/ready and one command.
// Depends on nothing.
`default_nettype none
interface lpcd_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] command;
  logic [7:0] data_byte;
  logic [2:0] channel;
  logic [6:0] request_count;

  modport source (output valid, command, data_byte, channel, request_count, input ready);
  modport sink   (input valid, command, data_byte, channel, request_count, output ready);
endinterface
`default_nettype wire

@@ src/lpcd_out_if.sv @@
// Result channel interface of the demultiplexer: valid/ready and one result.
// Depends on nothing.
`default_nettype none
interface lpcd_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] status;
  logic [7:0] out_byte;
  logic [7:0] out_channel;
  logic [8:0] fill_count;
  logic [8:0] new_count;
  logic       last;

  modport source (output valid, status, out_byte, out_channel, fill_count, new_count, last,
                  input ready);
  modport sink   (input valid, status, out_byte, out_channel, fill_count, new_count, last,
                  output ready);
endinterface
`default_nettype wire

@@ src/lpcd_ram.sv @@
// Generic single-write, single-read RAM with a registered, read-first output.
// Depends on nothing.
`default_nettype none
module lpcd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end
endmodule
`default_nettype wire

@@ src/lpcd_front.sv @@
// Front end: frame parser, per-channel counters and command decoding.
// Depends on lpcd_pkg and lpcd_in_if.
`default_nettype none
module lpcd_front (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            cfg_we_i,
  input  wire logic [7:0]      cfg_wdata_i,
  lpcd_in_if.sink              in_if,
  input  wire lpcd_pkg::q_stat_t q_stat_i,
  output logic                 push_o,
  output lpcd_pkg::desc_t      desc_o,
  output lpcd_pkg::wr_t        wr_o
);
  localparam logic [lpcd_pkg::CNT_W:0] DEPTH_X = (lpcd_pkg::CNT_W+1)'(lpcd_pkg::CHANNEL_DEPTH);
  localparam logic [lpcd_pkg::BURST_W-1:0] BURST_MAX =
    lpcd_pkg::BURST_W'(lpcd_pkg::MAX_BURST);

  logic [7:0]  en_q;
  logic [2:0]  hdr_q, hdr_d;
  logic [31:0] rem_q, rem_d;
  logic [7:0]  fch_q, fch_d;
  logic [8:0]  fwr_q, fwr_d;
  logic        fdis_q, fdis_d;
  logic [lpcd_pkg::POS_W-1:0] head_q [lpcd_pkg::NUM_CHANNELS];
  logic [lpcd_pkg::POS_W-1:0] head_d [lpcd_pkg::NUM_CHANNELS];
  logic [8:0] held_q  [lpcd_pkg::NUM_CHANNELS];
  logic [8:0] held_d  [lpcd_pkg::NUM_CHANNELS];
  logic [8:0] fresh_q [lpcd_pkg::NUM_CHANNELS];
  logic [8:0] fresh_d [lpcd_pkg::NUM_CHANNELS];
  logic acc;

  function automatic logic usable(input logic [7:0] ch, input logic [7:0] en);
    logic ok;
    ok = (9'(ch) < 9'(lpcd_pkg::NUM_CHANNELS)) && (ch < 8'd8);
    return ok && en[ch[2:0]];
  endfunction

  assign in_if.ready = !q_stat_i.full &&
                       !(in_if.command == lpcd_pkg::CMD_LINK && q_stat_i.burst_pending);
  assign acc    = in_if.valid && in_if.ready;
  assign push_o = acc;

  always_comb begin
    logic [lpcd_pkg::CH_W-1:0] c;
    logic [lpcd_pkg::CH_W-1:0] bi;
    logic [31:0]               pay;
    logic [lpcd_pkg::CNT_W:0]  space;
    logic                      dis;
    logic                      found;
    logic [lpcd_pkg::BURST_W-1:0] req;
    logic [lpcd_pkg::BURST_W-1:0] n;
    logic [7:0]                chb;
    hdr_d  = hdr_q;
    rem_d  = rem_q;
    fch_d  = fch_q;
    fwr_d  = fwr_q;
    fdis_d = fdis_q;
    head_d  = head_q;
    held_d  = held_q;
    fresh_d = fresh_q;
    desc_o = '0;
    wr_o   = '0;
    c      = fch_q[lpcd_pkg::CH_W-1:0];
    bi     = in_if.data_byte[lpcd_pkg::CH_W-1:0];
    pay    = rem_q - 32'd1;
    space  = '0;
    dis    = 1'b0;
    found  = 1'b0;
    req    = BURST_MAX;
    n      = '0;
    chb    = 8'(in_if.channel);
    unique case (in_if.command)
      lpcd_pkg::CMD_LINK: begin
        if (hdr_q < lpcd_pkg::HDR_CHAN) begin
          rem_d = {rem_q[23:0], in_if.data_byte};
          hdr_d = hdr_q + 3'd1;
        end else if (hdr_q == lpcd_pkg::HDR_CHAN) begin
          fch_d = in_if.data_byte;
          fwr_d = '0;
          desc_o.chan = in_if.data_byte;
          if (rem_q == 32'd0) begin
            hdr_d = '0;
            desc_o.status = lpcd_pkg::ST_BADLEN;
          end else begin
            rem_d = pay;
            space = DEPTH_X - {1'b0, held_q[bi]};
            if (!usable(in_if.data_byte, en_q)) begin
              desc_o.status = lpcd_pkg::ST_IGNORED;
              dis = 1'b1;
            end else if (pay > 32'(space)) begin
              desc_o.status = lpcd_pkg::ST_OVERRUN;
              dis = 1'b1;
            end
            fdis_d = dis;
            if (pay == 32'd0) begin
              hdr_d = '0;
              if (!dis) begin
                fresh_d[bi]   = '0;
                desc_o.status = lpcd_pkg::ST_COMMIT;
              end
            end else begin
              hdr_d = lpcd_pkg::HDR_BODY;
            end
          end
          if (9'(in_if.data_byte) < 9'(lpcd_pkg::NUM_CHANNELS)) begin
            desc_o.fill  = held_d[bi];
            desc_o.fresh = fresh_d[bi];
          end
        end else begin
          space = DEPTH_X - {1'b0, held_q[c]};
          if (!fdis_q && 9'(fch_q) < 9'(lpcd_pkg::NUM_CHANNELS)) begin
            if ({1'b0, fwr_q} < space) begin
              wr_o.we   = 1'b1;
              wr_o.addr = {c, lpcd_pkg::POS_W'(head_q[c] + held_q[c][lpcd_pkg::POS_W-1:0]
                                                 + fwr_q[lpcd_pkg::POS_W-1:0])};
              wr_o.data = in_if.data_byte;
              fwr_d = fwr_q + 9'd1;
            end
          end
          rem_d = rem_q - 32'd1;
          if (rem_d == 32'd0) begin
            hdr_d = '0;
            if (!fdis_q && 9'(fch_q) < 9'(lpcd_pkg::NUM_CHANNELS)) begin
              held_d[c]  = held_q[c] + fwr_d;
              fresh_d[c] = fwr_d;
              desc_o.status = lpcd_pkg::ST_COMMIT;
              desc_o.chan   = fch_q;
              desc_o.fill   = held_d[c];
              desc_o.fresh  = fwr_d;
            end
          end
        end
      end
      lpcd_pkg::CMD_SELECT: begin
        for (int k = 0; k < lpcd_pkg::NUM_CHANNELS; k++) begin
          if (!found && usable(8'(k), en_q) && held_q[k] != '0 && fresh_q[k] != '0) begin
            found = 1'b1;
            fresh_d[k]  = '0;
            desc_o.chan = 8'(k);
            desc_o.fill = held_q[k];
          end
        end
        if (!found) begin
          desc_o.status = lpcd_pkg::ST_NONE;
        end
      end
      default: begin
        if (in_if.command > lpcd_pkg::CMD_CLEAR || !usable(chb, en_q)) begin
          desc_o.status = lpcd_pkg::ST_IGNORED;
        end else begin
          c = in_if.channel[lpcd_pkg::CH_W-1:0];
          desc_o.chan = chb;
          if (in_if.command == lpcd_pkg::CMD_POP || in_if.command == lpcd_pkg::CMD_PEEK) begin
            if (in_if.request_count != '0 &&
                7'(in_if.request_count) <= 7'(lpcd_pkg::MAX_BURST)) begin
              req = lpcd_pkg::BURST_W'(in_if.request_count);
            end
            if (held_q[c] < 9'(req)) begin
              n = lpcd_pkg::BURST_W'(held_q[c]);
            end else begin
              n = req;
            end
            if (n == '0) begin
              desc_o.status = lpcd_pkg::ST_EMPTY;
            end else begin
              desc_o.burst = 1'b1;
              desc_o.head  = head_q[c];
              desc_o.cnt   = n;
              if (in_if.command == lpcd_pkg::CMD_POP) begin
                head_d[c] = head_q[c] + lpcd_pkg::POS_W'(n);
                held_d[c] = held_q[c] - 9'(n);
                fresh_d[c] = (fresh_q[c] > 9'(n)) ? fresh_q[c] - 9'(n) : '0;
              end
            end
          end else if (in_if.command == lpcd_pkg::CMD_UNMARK) begin
            fresh_d[c] = '0;
          end else begin
            head_d[c]  = '0;
            held_d[c]  = '0;
            fresh_d[c] = '0;
            if (hdr_q == lpcd_pkg::HDR_BODY && fch_q == chb) begin
              fdis_d = 1'b1;
            end
          end
          desc_o.fill  = held_d[c];
          desc_o.fresh = fresh_d[c];
        end
      end
    endcase
    if (!acc) begin
      wr_o.we = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      en_q   <= '0;
      hdr_q  <= '0;
      rem_q  <= '0;
      fch_q  <= '0;
      fwr_q  <= '0;
      fdis_q <= 1'b0;
      for (int k = 0; k < lpcd_pkg::NUM_CHANNELS; k++) begin
        head_q[k]  <= '0;
        held_q[k]  <= '0;
        fresh_q[k] <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        en_q <= cfg_wdata_i;
      end
      if (acc) begin
        hdr_q   <= hdr_d;
        rem_q   <= rem_d;
        fch_q   <= fch_d;
        fwr_q   <= fwr_d;
        fdis_q  <= fdis_d;
        head_q  <= head_d;
        held_q  <= held_d;
        fresh_q <= fresh_d;
      end
    end
  end
endmodule
`default_nettype wire

@@ src/lpcd_queue.sv @@
// Two-entry descriptor queue between the front end and the back end.
// Depends on lpcd_pkg.
`default_nettype none
module lpcd_queue (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push_i,
  input  wire lpcd_pkg::desc_t desc_i,
  input  wire logic            pop_i,
  output lpcd_pkg::desc_t      head_o,
  output lpcd_pkg::q_stat_t    stat_o
);
  lpcd_pkg::desc_t ent_q [2];
  logic [1:0] vld_q, vld_d;
  logic       wp_q, rp_q;

  assign head_o = ent_q[rp_q];
  assign stat_o.full  = &vld_q;
  assign stat_o.empty = ~|vld_q;
  assign stat_o.burst_pending = (vld_q[0] && ent_q[0].burst) || (vld_q[1] && ent_q[1].burst);

  always_comb begin
    vld_d = vld_q;
    if (push_i) begin
      vld_d[wp_q] = 1'b1;
    end
    if (pop_i) begin
      vld_d[rp_q] = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      ent_q[wp_q] <= desc_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
    end else begin
      vld_q <= vld_d;
      if (push_i) begin
        wp_q <= !wp_q;
      end
      if (pop_i) begin
        rp_q <= !rp_q;
      end
    end
  end
endmodule
`default_nettype wire

@@ src/lpcd_back.sv @@
// Back end: expands descriptors into results, reading burst bytes from the store.
// Depends on lpcd_pkg and lpcd_out_if.
`default_nettype none
module lpcd_back (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire lpcd_pkg::desc_t   head_i,
  input  wire lpcd_pkg::q_stat_t q_stat_i,
  output logic                   pop_o,
  output logic                   re_o,
  output logic [lpcd_pkg::ADDR_W-1:0] raddr_o,
  input  wire logic [7:0]        rdata_i,
  lpcd_out_if.source             out_if
);
  logic [lpcd_pkg::BURST_W-1:0] idx_q;
  logic       issue, is_last, p_move;
  logic       p_vld_q, p_ram_q, p_last_q;
  logic [2:0] p_st_q;
  logic [7:0] p_ch_q;
  logic [8:0] p_fill_q, p_new_q;
  logic       o_vld_q;

  assign p_move  = p_vld_q && (!o_vld_q || out_if.ready);
  assign issue   = !q_stat_i.empty && (!p_vld_q || p_move);
  assign is_last = !head_i.burst || (idx_q + 1'b1 == head_i.cnt);
  assign pop_o   = issue && is_last;
  assign re_o    = issue && head_i.burst;
  assign raddr_o = {head_i.chan[lpcd_pkg::CH_W-1:0],
                    lpcd_pkg::POS_W'(head_i.head + lpcd_pkg::POS_W'(idx_q))};
  assign out_if.valid = o_vld_q;

  always_ff @(posedge clk_i) begin
    if (issue) begin
      p_st_q   <= head_i.status;
      p_ch_q   <= head_i.chan;
      p_fill_q <= head_i.fill;
      p_new_q  <= head_i.fresh;
      p_ram_q  <= head_i.burst;
      p_last_q <= is_last;
    end
    if (p_move) begin
      out_if.status      <= p_st_q;
      out_if.out_byte    <= p_ram_q ? rdata_i : 8'd0;
      out_if.out_channel <= p_ch_q;
      out_if.fill_count  <= p_fill_q;
      out_if.new_count   <= p_new_q;
      out_if.last        <= p_last_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= '0;
      p_vld_q <= 1'b0;
      o_vld_q <= 1'b0;
    end else begin
      if (issue) begin
        idx_q <= is_last ? '0 : idx_q + 1'b1;
      end
      if (issue) begin
        p_vld_q <= 1'b1;
      end else if (p_move) begin
        p_vld_q <= 1'b0;
      end
      if (p_move) begin
        o_vld_q <= 1'b1;
      end else if (out_if.ready) begin
        o_vld_q <= 1'b0;
      end
    end
  end
endmodule
`default_nettype wire

@@ src/length_prefixed_channel_demux.sv @@
// Top level of the length-prefixed channel demultiplexer.
// Depends on lpcd_pkg, lpcd_in_if, lpcd_out_if, lpcd_ram, lpcd_front, lpcd_queue, lpcd_back.
//
//   Channel   Direction  Handshake     Carries
//   in_if     sink       valid/ready   command, data_byte, channel, request_count
//   out_if    source     valid/ready   status, out_byte, out_channel, fill_count,
//                                      new_count, last
//   cfg       write      cfg_we_i      channel_enable (8 bits)
//
// Every transaction on in_if is decoded as it is accepted and yields one result, except a read
// or peek, which yields one result per byte. The back end emits one result per cycle while
// out_if is ready, bounded by the single read port of the channel store; a result passes
// through the descriptor queue, the back end's pipeline register and its output register.
// Reset clears all counters and the parser; the store itself is not cleared, so there
// is no start-up pass. A link byte is held off while a read or peek is still queued, so
// that freshly received payload cannot overwrite bytes that are still to be read out.
`default_nettype none
module length_prefixed_channel_demux (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cfg_we_i,
  input  wire logic [7:0] cfg_wdata_i,
  lpcd_in_if.sink         in_if,
  lpcd_out_if.source      out_if
);
  logic              push;
  logic              pop;
  lpcd_pkg::desc_t   desc;
  lpcd_pkg::desc_t   head;
  lpcd_pkg::wr_t     wr;
  lpcd_pkg::q_stat_t q_stat;
  logic              re;
  logic [lpcd_pkg::ADDR_W-1:0] raddr;
  logic [7:0]        rdata;

  // The front end parses link bytes, keeps the per-channel counts and writes payload.
  lpcd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_if       (in_if),
    .q_stat_i    (q_stat),
    .push_o      (push),
    .desc_o      (desc),
    .wr_o        (wr)
  );

  // The queue lets the front end keep taking transactions while a burst drains.
  lpcd_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .desc_i (desc),
    .pop_i  (pop),
    .head_o (head),
    .stat_o (q_stat)
  );

  // The channel store: one circular buffer per channel, side by side.
  lpcd_ram #(
    .WIDTH (8),
    .DEPTH (lpcd_pkg::STORE_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (wr.we),
    .waddr_i (wr.addr),
    .wdata_i (wr.data),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // The back end turns each descriptor into its results.
  lpcd_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .head_i   (head),
    .q_stat_i (q_stat),
    .pop_o    (pop),
    .re_o     (re),
    .raddr_o  (raddr),
    .rdata_i  (rdata),
    .out_if   (out_if)
  );
endmodule
`default_nettype wire

@@ sim/length_prefixed_channel_demux_test.sv @@
// Self-checking testbench for the length-prefixed channel demultiplexer.
// Depends on lpcd_pkg, lpcd_in_if, lpcd_out_if and the block itself; it needs no files.
`default_nettype none
module length_prefixed_channel_demux_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 400000;

  // One command as it is offered on the input channel.
  typedef struct {
    logic [2:0] command;
    logic [7:0] data_byte;
    logic [2:0] channel;
    logic [6:0] request_count;
  } demux_command_t;

  // One result as the block should return it.
  typedef struct {
    logic [2:0] status;
    logic [7:0] out_byte;
    logic [7:0] out_channel;
    logic [8:0] fill_count;
    logic [8:0] new_count;
    logic       last;
  } demux_result_t;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [7:0] cfg_wdata_i;

  lpcd_in_if  in_if ();
  lpcd_out_if out_if ();

  length_prefixed_channel_demux dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_if      (in_if),
    .out_if     (out_if)
  );

  // Commands waiting to be offered, and results that the block still owes us.
  demux_command_t pending_commands[$];
  demux_result_t  owed_results[$];

  // Our own copy of the block's state, kept in step at every accepted transaction.
  logic [7:0]  byte_mirror[lpcd_pkg::NUM_CHANNELS][lpcd_pkg::CHANNEL_DEPTH];
  int unsigned head_mirror[lpcd_pkg::NUM_CHANNELS];
  int unsigned held_mirror[lpcd_pkg::NUM_CHANNELS];
  int unsigned fresh_mirror[lpcd_pkg::NUM_CHANNELS];
  int unsigned parse_index;
  logic [31:0] bytes_left;
  int unsigned frame_target;
  int unsigned frame_stored;
  bit          frame_dropped;
  logic [7:0]  enable_mirror;

  demux_command_t offered;
  int unsigned mismatches;
  int unsigned cycles;
  bit          steady_sender;  // no random idling on either side while set
  bit          hold_off_request;
  int unsigned hold_off_left;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic bit channel_usable(int unsigned ch);
    return ch < lpcd_pkg::NUM_CHANNELS && enable_mirror[ch];
  endfunction

  function automatic void owe(logic [2:0] st, logic [7:0] b, int unsigned ch,
                              int unsigned fill, int unsigned fresh, bit last);
    demux_result_t r;
    r.status      = st;
    r.out_byte    = b;
    r.out_channel = ch[7:0];
    r.fill_count  = fill[8:0];
    r.new_count   = fresh[8:0];
    r.last        = last;
    owed_results.push_back(r);
  endfunction

  function automatic void commit_frame();
    held_mirror[frame_target] += frame_stored;
    fresh_mirror[frame_target] = frame_stored;
  endfunction

  // Parser step for one byte from the link.
  function automatic void parse_link_byte(logic [7:0] b);
    logic [2:0]  st;
    longint      payload;
    int unsigned fill;
    int unsigned fresh;
    int unsigned c;
    if (parse_index < 4) begin
      bytes_left = {bytes_left[23:0], b};
      parse_index++;
      owe(lpcd_pkg::ST_OK, 8'd0, 0, 0, 0, 1'b1);
    end else if (parse_index == 4) begin
      st = lpcd_pkg::ST_OK;
      fill = 0;
      fresh = 0;
      frame_target = b;
      frame_stored = 0;
      if (bytes_left == 32'd0) begin
        parse_index = 0;
        st = lpcd_pkg::ST_BADLEN;
      end else begin
        bytes_left = bytes_left - 32'd1;
        payload = bytes_left;
        frame_dropped = 1'b0;
        if (!channel_usable(b)) begin
          st = lpcd_pkg::ST_IGNORED;
          frame_dropped = 1'b1;
        end else if (payload > longint'(lpcd_pkg::CHANNEL_DEPTH - held_mirror[b])) begin
          st = lpcd_pkg::ST_OVERRUN;
          frame_dropped = 1'b1;
        end
        if (payload == 0) begin
          // An empty payload commits straight away at the channel byte.
          parse_index = 0;
          if (!frame_dropped) begin
            commit_frame();
            st = lpcd_pkg::ST_COMMIT;
          end
        end else begin
          parse_index = 5;
        end
      end
      if (b < lpcd_pkg::NUM_CHANNELS) begin
        fill = held_mirror[b];
        fresh = fresh_mirror[b];
      end
      owe(st, 8'd0, b, fill, fresh, 1'b1);
    end else begin
      c = frame_target;
      if (!frame_dropped && c < lpcd_pkg::NUM_CHANNELS &&
          frame_stored < lpcd_pkg::CHANNEL_DEPTH - held_mirror[c]) begin
        byte_mirror[c][(head_mirror[c] + held_mirror[c] + frame_stored) %
                       lpcd_pkg::CHANNEL_DEPTH] = b;
        frame_stored++;
      end
      bytes_left = bytes_left - 32'd1;
      if (bytes_left == 32'd0) begin
        parse_index = 0;
        if (!frame_dropped && c < lpcd_pkg::NUM_CHANNELS) begin
          commit_frame();
          owe(lpcd_pkg::ST_COMMIT, 8'd0, c, held_mirror[c], fresh_mirror[c], 1'b1);
          return;
        end
      end
      owe(lpcd_pkg::ST_OK, 8'd0, 0, 0, 0, 1'b1);
    end
  endfunction

  // Works out every result that one accepted command causes.
  function automatic void predict_results(demux_command_t t);
    int unsigned want;
    int unsigned n;
    int unsigned head;
    int unsigned ch;
    ch = t.channel;
    if (t.command == lpcd_pkg::CMD_LINK) begin
      parse_link_byte(t.data_byte);
      return;
    end
    if (t.command == lpcd_pkg::CMD_SELECT) begin
      for (int i = 0; i < lpcd_pkg::NUM_CHANNELS; i++) begin
        if (channel_usable(i) && held_mirror[i] > 0 && fresh_mirror[i] != 0) begin
          fresh_mirror[i] = 0;
          owe(lpcd_pkg::ST_OK, 8'd0, i, held_mirror[i], 0, 1'b1);
          return;
        end
      end
      owe(lpcd_pkg::ST_NONE, 8'd0, 0, 0, 0, 1'b1);
      return;
    end
    if (t.command > lpcd_pkg::CMD_CLEAR || !channel_usable(ch)) begin
      owe(lpcd_pkg::ST_IGNORED, 8'd0, 0, 0, 0, 1'b1);
      return;
    end
    case (t.command)
      lpcd_pkg::CMD_POP, lpcd_pkg::CMD_PEEK: begin
        want = t.request_count;
        if (want == 0 || want > lpcd_pkg::MAX_BURST) want = lpcd_pkg::MAX_BURST;
        n = held_mirror[ch] < want ? held_mirror[ch] : want;
        if (n == 0) begin
          owe(lpcd_pkg::ST_EMPTY, 8'd0, ch, held_mirror[ch], fresh_mirror[ch], 1'b1);
          return;
        end
        head = head_mirror[ch];
        if (t.command == lpcd_pkg::CMD_POP) begin
          head_mirror[ch] = (head + n) % lpcd_pkg::CHANNEL_DEPTH;
          held_mirror[ch] -= n;
          fresh_mirror[ch] = fresh_mirror[ch] > n ? fresh_mirror[ch] - n : 0;
        end
        for (int unsigned i = 0; i < n; i++) begin
          owe(lpcd_pkg::ST_OK, byte_mirror[ch][(head + i) % lpcd_pkg::CHANNEL_DEPTH], ch,
              held_mirror[ch], fresh_mirror[ch], i + 1 == n);
        end
      end
      lpcd_pkg::CMD_UNMARK: begin
        fresh_mirror[ch] = 0;
        owe(lpcd_pkg::ST_OK, 8'd0, ch, held_mirror[ch], 0, 1'b1);
      end
      default: begin
        // Clearing the channel of the frame in flight silently drops that frame.
        head_mirror[ch] = 0;
        held_mirror[ch] = 0;
        fresh_mirror[ch] = 0;
        if (parse_index == 5 && frame_target == ch) frame_dropped = 1'b1;
        owe(lpcd_pkg::ST_OK, 8'd0, ch, 0, 0, 1'b1);
      end
    endcase
  endfunction

  // Sender: offers queued commands, idles at random, and holds each one until taken.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
    end else begin
      if (in_if.valid && in_if.ready) predict_results(offered);
      if (!in_if.valid || in_if.ready) begin
        if (pending_commands.size() > 0 && (steady_sender || $urandom_range(99) >= 36)) begin
          offered = pending_commands.pop_front();
          in_if.valid         <= 1'b1;
          in_if.command       <= offered.command;
          in_if.data_byte     <= offered.data_byte;
          in_if.channel       <= offered.channel;
          in_if.request_count <= offered.request_count;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: checks every accepted result against the oldest one owed, and stalls
  // either at random or for one long hold-off when asked.
  always @(posedge clk_i or negedge rst_ni) begin
    demux_result_t want;
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
      hold_off_left = 0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (owed_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Unexpected result: status %0d byte %0h channel %0d", out_if.status,
                     out_if.out_byte, out_if.out_channel);
        end else begin
          want = owed_results.pop_front();
          if (out_if.status !== want.status || out_if.out_byte !== want.out_byte ||
              out_if.out_channel !== want.out_channel ||
              out_if.fill_count !== want.fill_count ||
              out_if.new_count !== want.new_count || out_if.last !== want.last) begin
            mismatches++;
            if (mismatches <= 10)
              $display("Mismatch: expected st %0d byte %0h ch %0d fill %0d new %0d last %0b,",
                       want.status, want.out_byte, want.out_channel, want.fill_count,
                       want.new_count, want.last,
                       " got st %0d byte %0h ch %0d fill %0d new %0d last %0b",
                       out_if.status, out_if.out_byte, out_if.out_channel,
                       out_if.fill_count, out_if.new_count, out_if.last);
          end
        end
      end
      if (hold_off_request && hold_off_left == 0) hold_off_left = 400;
      if (hold_off_left > 0) begin
        hold_off_left--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= steady_sender || $urandom_range(99) >= 36;
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic queue_command(logic [2:0] cmd, logic [7:0] b = 8'd0, logic [2:0] ch = 3'd0,
                               logic [6:0] want = 7'd8);
    demux_command_t t;
    t.command = cmd;
    t.data_byte = b;
    t.channel = ch;
    t.request_count = want;
    pending_commands.push_back(t);
  endtask

  task automatic queue_header(logic [31:0] length, logic [7:0] ch);
    for (int i = 3; i >= 0; i--) queue_command(lpcd_pkg::CMD_LINK, length[8*i +: 8]);
    queue_command(lpcd_pkg::CMD_LINK, ch);
  endtask

  task automatic queue_payload(int unsigned count);
    for (int unsigned i = 0; i < count; i++) queue_command(lpcd_pkg::CMD_LINK, 8'($urandom));
  endtask

  task automatic queue_frame(int unsigned payload, logic [7:0] ch);
    queue_header(payload + 1, ch);
    queue_payload(payload);
  endtask

  // Waits until the block has nothing left in hand, then lets the clock run on before returning.
  task automatic drain();
    while (pending_commands.size() > 0 || in_if.valid || owed_results.size() > 0)
      @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  task automatic write_enable(logic [7:0] mask);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= mask;
    enable_mirror = mask;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // A random mix of well-formed frames, broken frames and buffer commands.
  task automatic queue_random_traffic(int unsigned amount);
    int unsigned start;
    int unsigned pick;
    start = pending_commands.size();
    while (pending_commands.size() - start < amount) begin
      pick = $urandom_range(99);
      if (pick < 55) begin
        queue_frame($urandom_range(12), 8'($urandom_range(lpcd_pkg::NUM_CHANNELS - 1)));
      end else if (pick < 60) begin
        queue_frame($urandom_range(4), 8'($urandom));
      end else if (pick < 63) begin
        queue_header(32'd0, 8'($urandom));
      end else if (pick < 83) begin
        queue_command($urandom_range(1) ? lpcd_pkg::CMD_POP : lpcd_pkg::CMD_PEEK, 8'd0,
                      3'($urandom),
                      $urandom_range(9) == 0 ? 7'($urandom) : 7'($urandom_range(1, 16)));
      end else if (pick < 90) begin
        queue_command(lpcd_pkg::CMD_SELECT);
      end else if (pick < 95) begin
        queue_command(lpcd_pkg::CMD_UNMARK, 8'd0, 3'($urandom));
      end else if (pick < 98) begin
        queue_command(lpcd_pkg::CMD_CLEAR, 8'd0, 3'($urandom));
      end else begin
        queue_command(3'($urandom_range(6, 7)), 8'($urandom), 3'($urandom), 7'($urandom));
      end
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = 8'd0;
    in_if.valid = 1'b0;
    in_if.command = lpcd_pkg::CMD_LINK;
    in_if.data_byte = 8'd0;
    in_if.channel = 3'd0;
    in_if.request_count = 7'd1;
    out_if.ready = 1'b0;
    mismatches = 0;
    cycles = 0;
    steady_sender = 1'b0;
    hold_off_request = 1'b0;
    for (int c = 0; c < lpcd_pkg::NUM_CHANNELS; c++) begin
      head_mirror[c] = 0;
      held_mirror[c] = 0;
      fresh_mirror[c] = 0;
    end
    parse_index = 0;
    bytes_left = 0;
    frame_target = 0;
    frame_stored = 0;
    frame_dropped = 1'b0;
    enable_mirror = 8'd0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // With every channel disabled, frames and pops are ignored and a select finds no channel.
    queue_frame(2, 8'd0);
    queue_command(lpcd_pkg::CMD_POP, 8'd0, 3'd0, 7'd1);
    queue_command(lpcd_pkg::CMD_SELECT);
    drain();

    write_enable(8'hFF);
    // Payload extremes, an empty payload, a zero length and an out-of-range channel.
    queue_header(32'd3, 8'd2);
    queue_command(lpcd_pkg::CMD_LINK, 8'h00);
    queue_command(lpcd_pkg::CMD_LINK, 8'hFF);
    queue_frame(0, 8'd7);
    queue_header(32'd0, 8'd1);
    queue_frame(1, 8'd200);
    queue_command(lpcd_pkg::CMD_PEEK, 8'd0, 3'd2, 7'd0);
    queue_command(lpcd_pkg::CMD_POP, 8'd0, 3'd2, 7'd1);
    queue_command(lpcd_pkg::CMD_SELECT);
    queue_command(lpcd_pkg::CMD_SELECT);
    queue_command(lpcd_pkg::CMD_UNMARK, 8'd0, 3'd2);
    queue_command(lpcd_pkg::CMD_POP, 8'd0, 3'd2, 7'd127);
    queue_command(lpcd_pkg::CMD_POP, 8'd0, 3'd2, 7'd64);
    queue_command(3'd6);
    queue_command(3'd7);
    drain();

    // An enable change half way through a frame must not touch that frame.
    queue_header(32'd4, 8'd3);
    queue_command(lpcd_pkg::CMD_LINK, 8'h5A);
    drain();
    write_enable(8'h00);
    queue_payload(2);
    drain();
    write_enable(8'hFF);

    // Clearing the channel of a frame in progress drops the frame silently.
    queue_header(32'd5, 8'd4);
    queue_payload(2);
    queue_command(lpcd_pkg::CMD_CLEAR, 8'd0, 3'd4);
    queue_payload(2);
    queue_command(lpcd_pkg::CMD_CLEAR, 8'd0, 3'd0);
    queue_command(lpcd_pkg::CMD_POP, 8'd0, 3'd4, 7'd8);
    drain();

    // Random traffic: first a long hold-off on the result side while the sender keeps
    // offering transactions, then a stretch without idling, then ordinary traffic.
    queue_random_traffic(20);
    @(negedge clk_i);
    hold_off_request = 1'b1;
    @(negedge clk_i);
    hold_off_request = 1'b0;
    drain();
    write_enable(8'hA5);
    steady_sender = 1'b1;
    queue_random_traffic(35);
    drain();
    steady_sender = 1'b0;
    write_enable(8'h5A);
    queue_random_traffic(20);
    drain();
    write_enable(8'hFF);
    queue_random_traffic(20);
    drain();

    // A payload longer than a whole channel can never fit and is dropped at the channel
    // byte; the frame is left unfinished, and commands still work in the meantime.
    queue_header(32'd258, 8'd0);
    queue_payload(2);
    queue_command(lpcd_pkg::CMD_PEEK, 8'd0, 3'd0, 7'd64);
    queue_command(lpcd_pkg::CMD_SELECT);
    drain();
    repeat (20) @(posedge clk_i);

    if (mismatches == 0 && owed_results.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
`default_nettype wire

@@ files.f @@
src/lpcd_pkg.sv
src/lpcd_in_if.sv
src/lpcd_out_if.sv
src/lpcd_ram.sv
src/lpcd_front.sv
src/lpcd_queue.sv
src/lpcd_back.sv
src/length_prefixed_channel_demux.sv
sim/length_prefixed_channel_demux_test.sv
